FILE: sv/humidity_sensor_frame_checker_defines.svh
// Assertion macros for the humidity sensor frame checker.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef HUMIDITY_SENSOR_FRAME_CHECKER_DEFINES_SVH
`define HUMIDITY_SENSOR_FRAME_CHECKER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, held off during reset
`define HSFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsfc assertion failed");
// next-cycle implication, held off during reset
`define HSFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsfc assertion failed");
`else
`define HSFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HSFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/hsfc_pkg.sv
// Package for the humidity sensor frame checker: types, constants, CRC-8 and
// the divide-by-full-scale helper. No dependencies.
`default_nettype none

package hsfc_pkg;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TEMP_BAD = 2'd1,
        ST_HUM_BAD  = 2'd2
    } t_status;

    // byte positions within a frame
    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [15:0] FULL_SCALE  = 16'hFFFF;
    localparam int          PROD_W      = 31;
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    // half of the full scale, rounded down: gives round-half-up after the divide
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32767);

    typedef struct packed {
        t_status     status;
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
    } t_frame;

    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // floor(m / 65535): m = hi*65536 + lo, and hi + lo stays below twice 65535
    function automatic logic [14:0] div_full_scale(input logic [PROD_W-1:0] m);
        logic [14:0] hi;
        logic [16:0] s;
        hi = m[PROD_W-1:16];
        s  = 17'(hi) + 17'(m[15:0]);
        return hi + 15'(s >= 17'(FULL_SCALE));
    endfunction

endpackage

`default_nettype wire

FILE: sv/hsfc_in_if.sv
// Input channel of the humidity sensor frame checker: one frame byte per item.
// No dependencies.
`default_nettype none

interface hsfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       frame_start;

    modport source (output valid, output byte_value, output frame_start, input ready);
    modport sink   (input valid, input byte_value, input frame_start, output ready);
endinterface

`default_nettype wire

FILE: sv/hsfc_out_if.sv
// Output channel of the humidity sensor frame checker: one result per frame.
// Depends on hsfc_pkg.
`default_nettype none

interface hsfc_out_if;
    logic               valid;
    logic               ready;
    hsfc_pkg::t_status  status;
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;

    modport source (output valid, output status, output temperature_centi,
                    output humidity_centi, input ready);
    modport sink   (input valid, input status, input temperature_centi,
                    input humidity_centi, output ready);
endinterface

`default_nettype wire

FILE: sv/hsfc_frame.sv
// Frame assembly: input register, byte position, running CRC-8 and word capture;
// emits one frame record after the sixth byte. Depends on hsfc_pkg, hsfc_in_if.
`default_nettype none

module hsfc_frame (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    hsfc_in_if.sink            i_in,
    output logic               o_frm_valid,
    output hsfc_pkg::t_frame   o_frm,
    input  wire logic          i_frm_ready
);

    logic             r_in_v;
    logic [7:0]       r_byte;
    logic             r_start;
    logic [2:0]       r_pos,  n_pos;
    logic [7:0]       r_crc,  n_crc;
    logic [15:0]      r_traw, n_traw;
    logic [15:0]      r_hraw, n_hraw;
    logic             r_tbad, n_tbad;
    logic             r_frm_v, n_frm_v;
    hsfc_pkg::t_frame r_frm, n_frm;

    logic       frm_en;
    logic       in_ready;
    logic       take;
    logic       done;
    logic       hum_bad;
    logic [2:0] pos;
    logic [7:0] crc_seed;
    logic [7:0] crc_new;

    assign frm_en   = !r_frm_v || i_frm_ready;
    assign in_ready = !r_in_v || frm_en;
    assign take     = r_in_v && frm_en;
    assign i_in.ready = in_ready;

    always_comb begin
        // frame start restarts the count; unused positions count as the first byte
        pos = (r_start || r_pos > hsfc_pkg::POS_H_CRC) ? hsfc_pkg::POS_T_MSB : r_pos;
        crc_seed = (pos == hsfc_pkg::POS_T_MSB || pos == hsfc_pkg::POS_H_MSB)
                   ? hsfc_pkg::CRC_INIT : r_crc;
        crc_new  = hsfc_pkg::crc8_feed(crc_seed, r_byte);
        hum_bad  = (r_crc != r_byte);

        n_pos  = r_pos;
        n_crc  = r_crc;
        n_traw = r_traw;
        n_hraw = r_hraw;
        n_tbad = r_tbad;
        done   = 1'b0;

        if (take) begin
            case (pos)
                hsfc_pkg::POS_T_MSB: begin
                    n_crc  = crc_new;
                    n_traw = {r_byte, 8'h00};
                    n_pos  = hsfc_pkg::POS_T_LSB;
                end
                hsfc_pkg::POS_T_LSB: begin
                    n_crc  = crc_new;
                    n_traw = {r_traw[15:8], r_byte};
                    n_pos  = hsfc_pkg::POS_T_CRC;
                end
                hsfc_pkg::POS_T_CRC: begin
                    n_tbad = (r_crc != r_byte);
                    n_crc  = hsfc_pkg::CRC_INIT;
                    n_pos  = hsfc_pkg::POS_H_MSB;
                end
                hsfc_pkg::POS_H_MSB: begin
                    n_crc  = crc_new;
                    n_hraw = {r_byte, 8'h00};
                    n_pos  = hsfc_pkg::POS_H_LSB;
                end
                hsfc_pkg::POS_H_LSB: begin
                    n_crc  = crc_new;
                    n_hraw = {r_hraw[15:8], r_byte};
                    n_pos  = hsfc_pkg::POS_H_CRC;
                end
                hsfc_pkg::POS_H_CRC: begin
                    n_crc  = hsfc_pkg::CRC_INIT;
                    n_pos  = hsfc_pkg::POS_T_MSB;
                    done   = 1'b1;
                end
                default: begin
                    n_pos = r_pos;
                end
            endcase
        end

        // temperature mismatch wins over humidity mismatch
        n_frm.status   = r_tbad ? hsfc_pkg::ST_TEMP_BAD
                       : (hum_bad ? hsfc_pkg::ST_HUM_BAD : hsfc_pkg::ST_OK);
        n_frm.temp_raw = r_traw;
        n_frm.hum_raw  = r_hraw;

        n_frm_v = r_frm_v;
        if (frm_en) begin
            n_frm_v = take && done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_pos   <= hsfc_pkg::POS_T_MSB;
            r_crc   <= hsfc_pkg::CRC_INIT;
            r_traw  <= '0;
            r_hraw  <= '0;
            r_tbad  <= 1'b0;
            r_frm_v <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_v <= i_in.valid;
            end
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_traw  <= n_traw;
            r_hraw  <= n_hraw;
            r_tbad  <= n_tbad;
            r_frm_v <= n_frm_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_byte  <= i_in.byte_value;
            r_start <= i_in.frame_start;
        end
        if (take && done) begin
            r_frm <= n_frm;
        end
    end

    assign o_frm_valid = r_frm_v;
    assign o_frm       = r_frm;

endmodule

`default_nettype wire

FILE: sv/hsfc_scale.sv
// Scaling of the raw words to hundredths: product register, then rounding
// divide by full scale and offset into the result register.
// Depends on hsfc_pkg, hsfc_out_if.
`default_nettype none

module hsfc_scale (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_frm_valid,
    input  hsfc_pkg::t_frame     i_frm,
    output logic                 o_frm_ready,
    hsfc_out_if.source           o_out
);

    logic                        r_prod_v;
    hsfc_pkg::t_status           r_prod_st;
    logic [hsfc_pkg::PROD_W-1:0] r_prod_t;
    logic [hsfc_pkg::PROD_W-1:0] r_prod_h;

    logic                        r_out_v;
    hsfc_pkg::t_status           r_status,   n_status;
    logic [14:0]                 r_temp,     n_temp;
    logic [13:0]                 r_hum,      n_hum;

    logic                        prod_en;
    logic                        out_en;
    logic [14:0]                 q_t;
    logic [14:0]                 q_h;

    assign out_en      = !r_out_v || o_out.ready;
    assign prod_en     = !r_prod_v || out_en;
    assign o_frm_ready = prod_en;

    always_comb begin
        q_t = hsfc_pkg::div_full_scale(r_prod_t + hsfc_pkg::ROUND_HALF);
        q_h = hsfc_pkg::div_full_scale(r_prod_h + hsfc_pkg::ROUND_HALF);
        n_status = r_prod_st;
        // a CRC mismatch zeroes both readings
        if (r_prod_st == hsfc_pkg::ST_OK) begin
            n_temp = q_t - hsfc_pkg::TEMP_OFFSET;
            n_hum  = q_h[13:0];
        end else begin
            n_temp = '0;
            n_hum  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (prod_en) begin
                r_prod_v <= i_frm_valid;
            end
            if (out_en) begin
                r_out_v <= r_prod_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (prod_en && i_frm_valid) begin
            r_prod_st <= i_frm.status;
            r_prod_t  <= hsfc_pkg::PROD_W'(i_frm.temp_raw) * hsfc_pkg::PROD_W'(hsfc_pkg::TEMP_SPAN);
            r_prod_h  <= hsfc_pkg::PROD_W'(i_frm.hum_raw) * hsfc_pkg::PROD_W'(hsfc_pkg::HUM_SPAN);
        end
        if (out_en && r_prod_v) begin
            r_status <= n_status;
            r_temp   <= n_temp;
            r_hum    <= n_hum;
        end
    end

    assign o_out.valid             = r_out_v;
    assign o_out.status            = r_status;
    assign o_out.temperature_centi = $signed(r_temp);
    assign o_out.humidity_centi    = r_hum;

endmodule

`default_nettype wire

FILE: sv/humidity_sensor_frame_checker.sv
// Top level of the humidity sensor frame checker: frame assembly and scaling.
// Depends on hsfc_pkg, hsfc_in_if, hsfc_out_if, hsfc_frame, hsfc_scale.
//
//   channel  dir  payload                                         items
//   i_in     in   byte_value[7:0], frame_start                    one per frame byte
//   o_out    out  status[1:0], temperature_centi[14:0] signed,    one per complete frame
//                 humidity_centi[13:0]
//
// One byte is taken per cycle unless the input is stalled. A frame's result
// passes the input, frame, product and result registers after its sixth
// byte is accepted. Synchronous reset clears the byte count, CRC and stored
// words; no clearing pass. Each stage advances when the one after it is
// free, so bytes keep entering while a result waits on o_out.ready.
`default_nettype none
`include "humidity_sensor_frame_checker_defines.svh"

module humidity_sensor_frame_checker (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    hsfc_in_if.sink     i_in,
    hsfc_out_if.source  o_out
);

    logic             frm_valid;
    logic             frm_ready;
    hsfc_pkg::t_frame frm;

    hsfc_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_frm_valid (frm_valid),
        .o_frm       (frm),
        .i_frm_ready (frm_ready)
    );

    hsfc_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frm_valid (frm_valid),
        .i_frm       (frm),
        .o_frm_ready (frm_ready),
        .o_out       (o_out)
    );

    // input backs up only when every stage holds an item and o_out is stalled
    `HSFC_ASSERT_IMP(a_stall_from_output, i_clk, i_rst_n, !i_in.ready,
        o_out.valid && !o_out.ready)
    // a CRC mismatch carries zero readings
    `HSFC_ASSERT_IMP(a_bad_frame_zero, i_clk, i_rst_n,
        o_out.valid && o_out.status != hsfc_pkg::ST_OK,
        o_out.temperature_centi == 15'sd0 && o_out.humidity_centi == 14'd0)
    // a good frame stays within the sensor range
    `HSFC_ASSERT_IMP(a_good_frame_range, i_clk, i_rst_n,
        o_out.valid && o_out.status == hsfc_pkg::ST_OK,
        o_out.humidity_centi <= 14'd10000 && o_out.temperature_centi >= -15'sd4500
            && o_out.temperature_centi <= 15'sd13000)
    // a stalled frame record holds its value
    `HSFC_ASSERT_NXT(a_frame_held, i_clk, i_rst_n, frm_valid && !frm_ready,
        frm_valid && $stable(frm))

endmodule

`default_nettype wire

FILE: tb/humidity_sensor_frame_checker_test.sv
// Testbench for humidity_sensor_frame_checker: six-byte measurement frames, truncated
// frames and stray bytes in, CRC status and scaled readings out, checked against a local predictor.
// Depends on hsfc_pkg, hsfc_in_if, hsfc_out_if and the checker RTL.
`timescale 1ns / 1ps

module humidity_sensor_frame_checker_test;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int STIMULUS_SIZE = 1050;
    localparam int HOLDOFF_AFTER = 300;
    localparam int HOLDOFF_LEN   = 120;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct packed {
        logic [7:0] value;
        logic       start;
    } t_frame_byte;

    typedef struct packed {
        hsfc_pkg::t_status  status;
        logic signed [14:0] temperature;
        logic [13:0]        humidity;
    } t_reading;

    logic i_clk;
    logic i_rst_n;

    hsfc_in_if  in_if ();
    hsfc_out_if out_if ();

    humidity_sensor_frame_checker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_frame_byte pending_bytes[$];
    t_reading    expected_readings[$];

    // predictor state
    logic [2:0]  frame_pos = hsfc_pkg::POS_T_MSB;
    logic [7:0]  crc_acc   = hsfc_pkg::CRC_INIT;
    logic [15:0] t_word    = '0;
    logic [15:0] h_word    = '0;
    logic        t_crc_bad = 1'b0;

    int errors         = 0;
    int items_queued   = 0;
    int bytes_accepted = 0;
    int readings_seen  = 0;
    int ok_count       = 0;
    int temp_bad_count = 0;
    int hum_bad_count  = 0;
    int input_stalls   = 0;
    int cycle_count    = 0;
    int holdoff_left   = 0;
    bit holdoff_done   = 0;

    int send_gap = 0, send_left = 0;
    bit send_steady = 0;
    int recv_wait = 0, recv_left = 0;
    bit recv_steady = 0;

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ b[i];
            c  = {c[6:0], 1'b0} ^ (fb ? hsfc_pkg::CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic logic signed [14:0] to_centi_celsius(input logic [15:0] raw);
        longint unsigned num;
        num = 64'd2 * hsfc_pkg::TEMP_SPAN * raw + hsfc_pkg::FULL_SCALE;
        return 15'(num / (64'd2 * hsfc_pkg::FULL_SCALE) - hsfc_pkg::TEMP_OFFSET);
    endfunction

    function automatic logic [13:0] to_centi_percent(input logic [15:0] raw);
        longint unsigned num;
        num = 64'd2 * hsfc_pkg::HUM_SPAN * raw + hsfc_pkg::FULL_SCALE;
        return 14'(num / (64'd2 * hsfc_pkg::FULL_SCALE));
    endfunction

    // steady stretches draw no wait at all
    function automatic int draw_wait(inout int left, inout bit steady);
        if (left == 0) begin
            steady = ($urandom_range(0, 2) == 0);
            left   = $urandom_range(20, 80);
        end else begin
            left--;
        end
        return steady ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 15))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 3));
            3: return 16'hFFFF - 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_error(input string msg);
        errors++;
        if (errors <= 10) begin
            $display("ERROR: %s", msg);
        end
    endtask

    task automatic push_byte(input logic [7:0] value, input logic start);
        t_frame_byte fb;
        fb.value = value;
        fb.start = start;
        pending_bytes.push_back(fb);
        items_queued++;
    endtask

    task automatic add_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                             input logic start, input bit bad_t, input bit bad_h);
        logic [7:0] crc;
        crc = crc8_step(crc8_step(hsfc_pkg::CRC_INIT, t_raw[15:8]), t_raw[7:0]);
        if (bad_t) begin
            crc ^= 8'($urandom_range(1, 255));
        end
        push_byte(t_raw[15:8], start);
        push_byte(t_raw[7:0], 1'b0);
        push_byte(crc, 1'b0);
        crc = crc8_step(crc8_step(hsfc_pkg::CRC_INIT, h_raw[15:8]), h_raw[7:0]);
        if (bad_h) begin
            crc ^= 8'($urandom_range(1, 255));
        end
        push_byte(h_raw[15:8], 1'b0);
        push_byte(h_raw[7:0], 1'b0);
        push_byte(crc, 1'b0);
    endtask

    // advance the frame predictor by one accepted item
    task automatic decode_frame_byte(input logic [7:0] b, input logic start);
        logic [2:0] pos;
        t_reading   rd;
        pos = start ? hsfc_pkg::POS_T_MSB : frame_pos;
        if (pos > hsfc_pkg::POS_H_CRC) begin
            pos = hsfc_pkg::POS_T_MSB;
        end
        case (pos)
            hsfc_pkg::POS_T_MSB: begin
                crc_acc   = crc8_step(hsfc_pkg::CRC_INIT, b);
                t_word    = {b, 8'h00};
                frame_pos = hsfc_pkg::POS_T_LSB;
            end
            hsfc_pkg::POS_T_LSB: begin
                crc_acc     = crc8_step(crc_acc, b);
                t_word[7:0] = b;
                frame_pos   = hsfc_pkg::POS_T_CRC;
            end
            hsfc_pkg::POS_T_CRC: begin
                t_crc_bad = (crc_acc != b);
                crc_acc   = hsfc_pkg::CRC_INIT;
                frame_pos = hsfc_pkg::POS_H_MSB;
            end
            hsfc_pkg::POS_H_MSB: begin
                crc_acc   = crc8_step(hsfc_pkg::CRC_INIT, b);
                h_word    = {b, 8'h00};
                frame_pos = hsfc_pkg::POS_H_LSB;
            end
            hsfc_pkg::POS_H_LSB: begin
                crc_acc     = crc8_step(crc_acc, b);
                h_word[7:0] = b;
                frame_pos   = hsfc_pkg::POS_H_CRC;
            end
            default: begin
                if (t_crc_bad || crc_acc != b) begin
                    rd.status      = t_crc_bad ? hsfc_pkg::ST_TEMP_BAD : hsfc_pkg::ST_HUM_BAD;
                    rd.temperature = '0;
                    rd.humidity    = '0;
                end else begin
                    rd.status      = hsfc_pkg::ST_OK;
                    rd.temperature = to_centi_celsius(t_word);
                    rd.humidity    = to_centi_percent(h_word);
                end
                expected_readings.push_back(rd);
                crc_acc   = hsfc_pkg::CRC_INIT;
                frame_pos = hsfc_pkg::POS_T_MSB;
            end
        endcase
    endtask

    always @(posedge i_clk) begin : drive_bytes
        t_frame_byte nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                decode_frame_byte(in_if.byte_value, in_if.frame_start);
                bytes_accepted <= bytes_accepted + 1;
            end
            if (in_if.valid && !in_if.ready && holdoff_left > 0) begin
                input_stalls <= input_stalls + 1;
            end
            if (!in_if.valid || in_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_if.valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    nxt = pending_bytes.pop_front();
                    in_if.byte_value  <= nxt.value;
                    in_if.frame_start <= nxt.start;
                    in_if.valid       <= 1'b1;
                    send_gap = draw_wait(send_left, send_steady);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_readings
        t_reading exp_rd;
        string    msg;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                readings_seen <= readings_seen + 1;
                if (expected_readings.size() == 0) begin
                    report_error($sformatf("unexpected reading status=%0d temp=%0d hum=%0d",
                        out_if.status, out_if.temperature_centi, out_if.humidity_centi));
                end else begin
                    exp_rd = expected_readings.pop_front();
                    if (out_if.status !== exp_rd.status
                            || out_if.temperature_centi !== exp_rd.temperature
                            || out_if.humidity_centi !== exp_rd.humidity) begin
                        msg = $sformatf("reading mismatch: expected status=%0d temp=%0d hum=%0d",
                            exp_rd.status, exp_rd.temperature, exp_rd.humidity);
                        msg = {msg, $sformatf(", got status=%0d temp=%0d hum=%0d",
                            out_if.status, out_if.temperature_centi, out_if.humidity_centi)};
                        report_error(msg);
                    end
                    case (exp_rd.status)
                        hsfc_pkg::ST_OK:       ok_count       <= ok_count + 1;
                        hsfc_pkg::ST_TEMP_BAD: temp_bad_count <= temp_bad_count + 1;
                        default:               hum_bad_count  <= hum_bad_count + 1;
                    endcase
                end
                recv_wait = draw_wait(recv_left, recv_steady);
            end else if (recv_wait > 0) begin
                recv_wait--;
            end
            out_if.ready <= (recv_wait == 0) && (holdoff_left == 0);
        end
    end

    // hold the receiver off once, long enough to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            holdoff_left <= 0;
        end else if (!holdoff_done && bytes_accepted >= HOLDOFF_AFTER) begin
            holdoff_left <= HOLDOFF_LEN;
            holdoff_done <= 1'b1;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("humidity_sensor_frame_checker verification failed");
            $finish;
        end
    end

    initial begin
        int sel;
        int len;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.byte_value  = '0;
        in_if.frame_start = 1'b0;
        out_if.ready      = 1'b0;

        // directed: zero and full-scale words, a frame with no start flag,
        // a bad temperature CRC, then an aborted frame restarted by the flag
        // ahead of a bad humidity CRC
        add_frame(16'h0000, 16'h0000, 1'b1, 0, 0);
        add_frame(16'hFFFF, 16'hFFFF, 1'b0, 0, 0);
        add_frame(16'h6666, 16'h8000, 1'b1, 1, 0);
        push_byte(8'hA5, 1'b1);
        push_byte(8'h5A, 1'b0);
        add_frame(16'h8000, 16'h1234, 1'b1, 0, 1);

        while (items_queued < STIMULUS_SIZE) begin
            sel = $urandom_range(0, 99);
            if (sel < 82) begin
                add_frame(pick_word(), pick_word(), $urandom_range(0, 9) != 0,
                          $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
            end else if (sel < 92) begin
                // truncated frame
                len = $urandom_range(1, 5);
                push_byte(8'($urandom), 1'b1);
                for (int i = 1; i < len; i++) begin
                    push_byte(8'($urandom), 1'b0);
                end
            end else begin
                push_byte(8'($urandom), 1'($urandom_range(0, 1)));
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || in_if.valid) begin
            @(negedge i_clk);
        end
        while (expected_readings.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_readings.size() != 0) begin
            report_error($sformatf("%0d readings never arrived", expected_readings.size()));
        end

        $display("sent %0d bytes, checked %0d readings, %0d errors",
                 bytes_accepted, readings_seen, errors);
        $display("%0d ok, %0d temperature CRC, %0d humidity CRC; %0d input stall cycles",
                 ok_count, temp_bad_count, hum_bad_count, input_stalls);
        if (errors == 0) begin
            $display("humidity_sensor_frame_checker verification clean");
        end else begin
            $display("humidity_sensor_frame_checker verification failed");
        end
        $finish;
    end

endmodule
